// ----- rtl/core/wdkc_pkg.sv -----
// Shared types and constants of the windowed distinct key counter.
package wdkc_pkg;

   localparam int KEY_WIDTH    = 64;
   localparam int WINDOW_WIDTH = 32;
   localparam int OUT_WIDTH    = 6;

   localparam logic ACT_RECORD = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   localparam logic [OUT_WIDTH-1:0] COUNT_MAX = 6'd63;

   typedef logic [KEY_WIDTH-1:0] key_type;

   typedef struct packed {
      logic clear;
      logic insert;
   } cam_ctl_type;

endpackage

// ----- rtl/core/wdkc_ring_mem.sv -----
// Event ring storage: key and timestamp memory, one write port, one registered read port.
module wdkc_ring_mem #(
   parameter int DEPTH      = 32,
   parameter int TIME_WIDTH = 48,
   localparam int AddrWidth = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AddrWidth-1:0]  wr_addr,
   input  wdkc_pkg::key_type     wr_key,
   input  logic [TIME_WIDTH-1:0] wr_time,
   input  logic [AddrWidth-1:0]  rd_addr,
   output wdkc_pkg::key_type     rd_key,
   output logic [TIME_WIDTH-1:0] rd_time
);
   import wdkc_pkg::*;

   key_type               key_mem  [DEPTH];
   logic [TIME_WIDTH-1:0] time_mem [DEPTH];
   key_type               rd_key_ff;
   logic [TIME_WIDTH-1:0] rd_time_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]  <= wr_key;
         time_mem[wr_addr] <= wr_time;
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff  <= key_mem[rd_addr];
      rd_time_ff <= time_mem[rd_addr];
   end

   assign rd_key  = rd_key_ff;
   assign rd_time = rd_time_ff;

endmodule

// ----- rtl/core/wdkc_seen_cam.sv -----
// Seen-key list for one query: parallel key match and append.
module wdkc_seen_cam #(
   parameter int DEPTH      = 32,
   localparam int CntWidth  = $clog2(DEPTH + 1),
   localparam int IdxWidth  = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  wdkc_pkg::cam_ctl_type   ctl,
   input  wdkc_pkg::key_type       ins_key,
   input  wdkc_pkg::key_type       look_key,
   output logic [DEPTH-1:0]        hit,
   output logic [CntWidth-1:0]     count
);
   import wdkc_pkg::*;

   key_type             entry_ff [DEPTH];
   logic [CntWidth-1:0] count_ff;
   logic [CntWidth-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.insert) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.insert) begin
         entry_ff[count_ff[IdxWidth-1:0]] <= ins_key;
      end
   end

   always_comb begin
      for (int e = 0; e < DEPTH; e++) begin
         hit[e] = (CntWidth'(e) < count_ff) && (entry_ff[e] == look_key);
      end
   end

   assign count = count_ff;

endmodule

// ----- rtl/core/windowed_distinct_key_counter_core.sv -----
// Top level of the windowed distinct key counter: control, slot valid bits and query pipeline.
//
// A record transfer writes the key and time into the ring slot at the write pointer and
// busy stays low, so records may follow each other in every cycle while no query is in
// progress. A query walks the ring through the single read port of the event memory, one
// slot per cycle, and then drains a three-stage pipeline (read, seen-key match, count);
// busy stays high while the query is in progress and falls in the cycle in which rsp_strobe
// marks the result, so the next transfer may start then. The result is shown for one cycle
// only and the receiver cannot stall it: it must take rsp_distinct_keys whenever rsp_strobe
// is high. The count saturates at 63.
module windowed_distinct_key_counter_core #(
   parameter int RING_DEPTH = 32,
   parameter int TIME_WIDTH = 48
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_action,
   input  wdkc_pkg::key_type                       req_layer_key,
   input  logic [TIME_WIDTH-1:0]                   req_now_ms,
   input  logic [wdkc_pkg::WINDOW_WIDTH-1:0]       req_window_ms,
   output logic                                    rsp_strobe,
   output logic [wdkc_pkg::OUT_WIDTH-1:0]          rsp_distinct_keys
);
   import wdkc_pkg::*;

   localparam int AddrWidth = $clog2(RING_DEPTH);
   localparam int CntWidth  = $clog2(RING_DEPTH + 1);
   localparam int CmpWidth  = (TIME_WIDTH > WINDOW_WIDTH) ? TIME_WIDTH : WINDOW_WIDTH;
   localparam int ExtWidth  = (CntWidth > OUT_WIDTH) ? CntWidth : OUT_WIDTH;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [AddrWidth-1:0]  rd_idx_ff, rd_idx_in;
   logic [AddrWidth-1:0]  wp_ff, wp_in;
   logic [RING_DEPTH-1:0] slot_valid_ff;

   logic                  all_ff;
   logic [TIME_WIDTH-1:0] cutoff_ff;

   logic                  rec_acc, query_acc, rd_last, wp_last, issue;

   key_type               rd_key;
   logic [TIME_WIDTH-1:0] rd_time;

   logic                  s1_vld_ff, s1_last_ff, s1_sv_ff;
   logic                  in_win1;
   logic                  s2_vld_ff, s2_last_ff, s2_inwin_ff;
   key_type               s2_key_ff;
   logic                  fwd2;
   logic                  s3_vld_ff, s3_last_ff, s3_inwin_ff, s3_fwd_ff;
   key_type               s3_key_ff;
   logic [RING_DEPTH-1:0] s3_hit_ff;
   logic                  new3, done3;

   cam_ctl_type           cam_ctl;
   logic [RING_DEPTH-1:0] cam_hit;
   logic [CntWidth-1:0]   seen_count;
   logic [CntWidth-1:0]   cnt_final;
   logic [ExtWidth-1:0]   cnt_ext;
   logic [OUT_WIDTH-1:0]  cnt_sat;

   logic                  rsp_strobe_ff;
   logic [OUT_WIDTH-1:0]  rsp_keys_ff;

   assign busy      = (state_ff != ST_IDLE);
   assign rec_acc   = start && !busy && (req_action == ACT_RECORD);
   assign query_acc = start && !busy && (req_action == ACT_QUERY);
   assign rd_last   = (rd_idx_ff == AddrWidth'(RING_DEPTH - 1));
   assign wp_last   = (wp_ff == AddrWidth'(RING_DEPTH - 1));
   assign issue     = (state_ff == ST_SCAN);
   assign done3     = s3_vld_ff && s3_last_ff;

   always_comb begin
      state_in  = state_ff;
      rd_idx_in = rd_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_acc) begin
               state_in  = ST_SCAN;
               rd_idx_in = '0;
            end
         end
         ST_SCAN: begin
            if (rd_last) begin
               state_in = ST_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (done3) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wp_in = wp_ff;
      if (rec_acc) begin
         wp_in = wp_last ? '0 : wp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_idx_ff     <= '0;
         wp_ff         <= '0;
         slot_valid_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rd_idx_ff <= rd_idx_in;
         wp_ff     <= wp_in;
         if (rec_acc) begin
            slot_valid_ff[wp_ff] <= 1'b1;
         end
      end
   end

   // hold the query's cutoff for the whole walk
   always_ff @(posedge clock) begin
      if (query_acc) begin
         all_ff    <= (CmpWidth'(req_window_ms) >= CmpWidth'(req_now_ms));
         cutoff_ff <= req_now_ms - TIME_WIDTH'(req_window_ms);
      end
   end

   wdkc_ring_mem #(
      .DEPTH      (RING_DEPTH),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (rec_acc),
      .wr_addr (wp_ff),
      .wr_key  (req_layer_key),
      .wr_time (req_now_ms),
      .rd_addr (rd_idx_ff),
      .rd_key  (rd_key),
      .rd_time (rd_time)
   );

   assign in_win1 = s1_sv_ff && (all_ff || (rd_time >= cutoff_ff));
   assign fwd2    = s3_vld_ff && s3_inwin_ff && (s2_key_ff == s3_key_ff);
   assign new3    = s3_vld_ff && s3_inwin_ff && !(|s3_hit_ff) && !s3_fwd_ff;

   assign cam_ctl.clear  = query_acc;
   assign cam_ctl.insert = new3;

   wdkc_seen_cam #(
      .DEPTH (RING_DEPTH)
   ) u_seen_cam (
      .clock    (clock),
      .reset    (reset),
      .ctl      (cam_ctl),
      .ins_key  (s3_key_ff),
      .look_key (s2_key_ff),
      .hit      (cam_hit),
      .count    (seen_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         s3_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_vld_ff     <= issue;
         s2_vld_ff     <= s1_vld_ff;
         s3_vld_ff     <= s2_vld_ff;
         rsp_strobe_ff <= done3;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff  <= rd_last;
      s1_sv_ff    <= slot_valid_ff[rd_idx_ff];
      s2_last_ff  <= s1_last_ff;
      s2_inwin_ff <= in_win1;
      s2_key_ff   <= rd_key;
      s3_last_ff  <= s2_last_ff;
      s3_inwin_ff <= s2_inwin_ff;
      s3_key_ff   <= s2_key_ff;
      s3_hit_ff   <= cam_hit;
      s3_fwd_ff   <= fwd2;
   end

   assign cnt_final = seen_count + CntWidth'(new3);
   assign cnt_ext   = ExtWidth'(cnt_final);
   assign cnt_sat   = (cnt_ext > ExtWidth'(COUNT_MAX)) ? COUNT_MAX : OUT_WIDTH'(cnt_ext);

   always_ff @(posedge clock) begin
      if (done3) begin
         rsp_keys_ff <= cnt_sat;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_distinct_keys = rsp_keys_ff;

`ifndef SYNTH
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (!s1_vld_ff && !s2_vld_ff && !s3_vld_ff))
      else $error("query pipeline active while idle");

   a_wp_advance: assert property (@(posedge clock) disable iff (reset)
      rec_acc |=> (wp_ff == ($past(wp_last) ? '0 : $past(wp_ff) + 1'b1)))
      else $error("write pointer did not advance on record transfer");

   a_rsp_after_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_strobe) |-> ($past(state_ff) == ST_DRAIN))
      else $error("result issued outside of pipeline drain");
`endif

endmodule

// ----- verif/windowed_distinct_key_counter_core_test.sv -----
// Testbench of the windowed distinct key counter core: directed and random traffic against a ring predictor.
`timescale 1ns / 1ps

module windowed_distinct_key_counter_core_test;
   import wdkc_pkg::*;

   localparam int RING_DEPTH   = 32;
   localparam int TIME_WIDTH   = 48;
   localparam int RANDOM_ITEMS = 500;
   localparam int STALL_LIMIT  = 4000;
   localparam int TAIL_CYCLES  = 2 * (RING_DEPTH + 4);
   localparam int QUIET_FIRST  = 260;
   localparam int QUIET_LAST   = 360;

   typedef logic [TIME_WIDTH-1:0]   stamp_type;
   typedef logic [WINDOW_WIDTH-1:0] window_type;
   typedef logic [OUT_WIDTH-1:0]    count_type;

   typedef struct {
      logic       action;
      key_type    key;
      stamp_type  now;
      window_type window;
      bit         drain;
   } command_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_action = ACT_RECORD;
   key_type    req_layer_key = '0;
   stamp_type  req_now_ms = '0;
   window_type req_window_ms = '0;
   logic       rsp_strobe;
   count_type  rsp_distinct_keys;

   command_type command_queue[$];
   count_type   expected_counts[$];
   command_type current;

   key_type   ring_keys  [RING_DEPTH];
   stamp_type ring_times [RING_DEPTH];
   logic      ring_valid [RING_DEPTH] = '{default: 1'b0};
   int        ring_wp = 0;

   int items_sent     = 0;
   int queries_sent   = 0;
   int results_seen   = 0;
   int mismatches     = 0;
   int stall_cycles   = 0;

   windowed_distinct_key_counter_core #(
      .RING_DEPTH(RING_DEPTH),
      .TIME_WIDTH(TIME_WIDTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_layer_key    (req_layer_key),
      .req_now_ms       (req_now_ms),
      .req_window_ms    (req_window_ms),
      .rsp_strobe       (rsp_strobe),
      .rsp_distinct_keys(rsp_distinct_keys)
   );

   always #6 clock = ~clock;

   function automatic count_type count_recent_keys(input stamp_type now, input window_type window);
      logic                  take_all;
      stamp_type             cutoff;
      logic [RING_DEPTH-1:0] live;
      logic                  repeated;
      int                    total;
      take_all = window >= now;
      cutoff = now - window;
      for (int i = 0; i < RING_DEPTH; i++)
         live[i] = ring_valid[i] && (take_all || ring_times[i] >= cutoff);
      total = 0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         if (live[i]) begin
            repeated = 1'b0;
            for (int j = 0; j < i; j++)
               if (live[j] && ring_keys[j] == ring_keys[i])
                  repeated = 1'b1;
            if (!repeated && total < COUNT_MAX)
               total++;
         end
      end
      return total[OUT_WIDTH-1:0];
   endfunction

   function automatic void apply_command(input command_type cmd);
      if (cmd.action == ACT_RECORD) begin
         ring_keys[ring_wp]  = cmd.key;
         ring_times[ring_wp] = cmd.now;
         ring_valid[ring_wp] = 1'b1;
         ring_wp = (ring_wp + 1) % RING_DEPTH;
      end else begin
         expected_counts.push_back(count_recent_keys(cmd.now, cmd.window));
      end
   endfunction

   function automatic void add_command(input logic action, input key_type key,
                                       input stamp_type now, input window_type window,
                                       input bit drain);
      command_type cmd;
      cmd.action = action;
      cmd.key    = key;
      cmd.now    = now;
      cmd.window = window;
      cmd.drain  = drain;
      command_queue.push_back(cmd);
   endfunction

   function automatic void report_mismatch(input string what, input int expected_value,
                                           input int actual_value);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch: %s expected %0d actual %0d at %0t", what, expected_value,
                  actual_value, $realtime);
   endfunction

   // Driver: hold a command until transfer, then pick the next one or idle.
   always @(posedge clock) begin : driver
      logic fire;
      logic quiet;
      fire = start && !busy;
      if (rsp_strobe === 1'b1)
         results_seen++;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (fire) begin
            apply_command(current);
            if (current.action == ACT_QUERY)
               queries_sent++;
            items_sent++;
         end
         if (!start || fire) begin
            quiet = items_sent >= QUIET_FIRST && items_sent < QUIET_LAST;
            if (command_queue.size() != 0
                && !(command_queue[0].drain && queries_sent != results_seen)
                && (quiet || $urandom_range(0, 99) >= 27)) begin
               current = command_queue.pop_front();
               req_action    <= current.action;
               req_layer_key <= current.key;
               req_now_ms    <= current.now;
               req_window_ms <= current.window;
               start         <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobe carries one count; compare with the oldest prediction.
   always @(posedge clock) begin : monitor
      count_type wanted;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (rsp_strobe !== 1'b1)
            report_mismatch("rsp_strobe unknown, strobe", 1, 0);
         else if (expected_counts.size() == 0)
            report_mismatch("unexpected result, distinct_keys", -1, rsp_distinct_keys);
         else begin
            wanted = expected_counts.pop_front();
            if (rsp_distinct_keys !== wanted)
               report_mismatch("distinct_keys", wanted, rsp_distinct_keys);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      key_type    key_pool [40];
      int         pool_size;
      bit         wide_keys;
      int         length;
      int         random_items;
      int         episodes;
      bit         drain;
      stamp_type  t;
      stamp_type  q_now;
      window_type q_window;
      bit         timed_out;

      // Directed: empty ring, extreme keys and times, duplicates, window edges.
      add_command(ACT_QUERY, {$urandom, $urandom}, '0, '0, 1'b0);
      add_command(ACT_RECORD, '0, '0, $urandom, 1'b0);
      add_command(ACT_RECORD, '1, '1, $urandom, 1'b0);
      add_command(ACT_QUERY, {$urandom, $urandom}, '0, '0, 1'b0);
      add_command(ACT_QUERY, {$urandom, $urandom}, '1, '0, 1'b0);
      add_command(ACT_QUERY, {$urandom, $urandom}, '1, '1, 1'b0);
      add_command(ACT_RECORD, '0, 48'd100, $urandom, 1'b0);
      add_command(ACT_QUERY, {$urandom, $urandom}, 48'd100, 32'd0, 1'b0);
      add_command(ACT_QUERY, {$urandom, $urandom}, 48'd100, 32'd100, 1'b0);
      add_command(ACT_QUERY, {$urandom, $urandom}, 48'd100, 32'd99, 1'b0);
      add_command(ACT_QUERY, {$urandom, $urandom}, 48'd100, 32'd101, 1'b0);
      add_command(ACT_QUERY, {$urandom, $urandom}, 48'd50, 32'd0, 1'b0);
      add_command(ACT_RECORD, 64'h5555_5555_5555_5555, 48'h1_0000_0000, '1, 1'b0);
      add_command(ACT_RECORD, 64'hAAAA_AAAA_AAAA_AAAA, 48'hFFFF_FFFF, '0, 1'b0);
      add_command(ACT_QUERY, '1, 48'h1_0000_0000, '1, 1'b0);
      add_command(ACT_QUERY, '0, 48'h1_0000_0000, 32'hFFFF_FFFE, 1'b0);
      add_command(ACT_QUERY, '0, 48'h1_0000_0001, '1, 1'b0);

      random_items = 0;
      episodes = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       t = stamp_type'($urandom_range(0, 1000));
            1:       t = stamp_type'({$urandom, $urandom});
            2:       t = '1 - $urandom_range(0, 3000);
            default: t = 48'h1_0000_0000 - $urandom_range(0, 2000);
         endcase
         pool_size = $urandom_range(1, 40);
         wide_keys = 1'($urandom_range(0, 1));
         for (int k = 0; k < pool_size; k++)
            key_pool[k] = wide_keys ? {$urandom, $urandom} : key_type'($urandom_range(0, 7));
         length = $urandom_range(10, 60);
         drain = episodes == 0 || $urandom_range(0, 3) == 0;
         for (int n = 0; n < length; n++) begin
            if ($urandom_range(0, 99) < 5) begin
               add_command(1'($urandom_range(0, 1)), {$urandom, $urandom},
                           stamp_type'({$urandom, $urandom}), $urandom, drain);
            end else if ($urandom_range(0, 99) < 72) begin
               add_command(ACT_RECORD, key_pool[$urandom_range(0, pool_size - 1)], t, $urandom,
                           drain);
            end else begin
               q_now = t;
               if ($urandom_range(0, 3) == 0)
                  q_now = t - $urandom_range(0, 60);
               case ($urandom_range(0, 5))
                  0:       q_window = '0;
                  1:       q_window = $urandom_range(0, 60);
                  2:       q_window = $urandom_range(0, 2000);
                  3:       q_window = $urandom;
                  4:       q_window = '1;
                  default: q_window = q_now[WINDOW_WIDTH-1:0] - $urandom_range(0, 2);
               endcase
               add_command(ACT_QUERY, {$urandom, $urandom}, q_now, q_window, drain);
            end
            drain = 1'b0;
            if ($urandom_range(0, 99) < 5)
               t = t - $urandom_range(0, 100);
            else
               t = t + $urandom_range(0, 40);
            random_items++;
         end
         episodes++;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while ((command_queue.size() != 0 || start || expected_counts.size() != 0)
             && stall_cycles < STALL_LIMIT)
         @(posedge clock);
      timed_out = stall_cycles >= STALL_LIMIT;
      if (!timed_out)
         repeat (TAIL_CYCLES) @(posedge clock);

      if (!timed_out && mismatches == 0 && expected_counts.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
